// ----- hw/rtl/tlss_pkg.sv -----
package tlss_pkg;

	localparam int unsigned FORCE_W = 17;
	localparam int unsigned SPAN_W = 16;
	localparam int unsigned RAMP_W = 7;
	localparam int unsigned CFG_IDX_W = 1;

	localparam int unsigned RAMP_TOP = 100;
	localparam int unsigned SHRINK_LIMIT = 480;
	localparam int unsigned RAMP_STEP_TICKS = 50;
	localparam int FORCE_MAX = 65535;
	localparam int FORCE_MIN = -65536;

	localparam logic [CFG_IDX_W-1:0] CFG_ENCODER_CENTER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TRANSITION_SPAN = 1'b1;

	typedef struct packed {
		logic load;
		logic rel;
		logic pen;
		logic diff;
		logic div_start;
		logic ramp_mul;
		logic ramp_div;
		logic fin;
	} tlss_cmd_t;

	typedef struct packed {
		logic skip;
		logic div_done;
	} tlss_stat_t;

endpackage

// ----- hw/rtl/tlss_div.sv -----
module tlss_div #(
	parameter int unsigned QW = 17,
	parameter int unsigned VW = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [VW+QW-1:0] dividend,
	input  logic [VW-1:0]    divisor,
	output logic             done,
	output logic [QW-1:0]    quotient
);

	localparam int unsigned CW = $clog2(QW);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dsr_q;
	logic [QW-1:0] dvd_q;
	logic [VW:0]   trial;
	logic [VW:0]   trial_sub;
	logic          ge;

	assign trial = {rem_q, dvd_q[QW-1]};
	assign ge = trial >= {1'b0, dsr_q};
	assign trial_sub = trial - {1'b0, dsr_q};
	assign done = busy_q && (cnt_q == CW'(QW - 1));
	assign quotient = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (cnt_q == CW'(QW - 1)) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[VW+QW-1:QW];
			dvd_q <= dividend[QW-1:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[VW-1:0] : trial[VW-1:0];
			dvd_q <= {dvd_q[QW-2:0], ge};
		end
	end

endmodule

// ----- hw/rtl/tlss_dp.sv -----
module tlss_dp #(
	parameter int unsigned FORCE_FULL_SCALE = 65535
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tlss_pkg::tlss_cmd_t                 cmd,
	output tlss_pkg::tlss_stat_t                stat,
	input  logic                                cfg_wr_en,
	input  logic [tlss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]                         cfg_data,
	input  logic [31:0]                         tick_now,
	input  logic [30:0]                         travel_half,
	input  logic signed [31:0]                  encoder_position,
	input  logic                                effects_disabled,
	input  logic signed [tlss_pkg::FORCE_W-1:0] force_in,
	output logic signed [tlss_pkg::FORCE_W-1:0] force_out,
	output logic                                damper_active
);

	localparam int unsigned QW = $clog2(FORCE_FULL_SCALE + 65537);
	localparam int unsigned SW = tlss_pkg::SPAN_W;
	localparam int unsigned RW = tlss_pkg::RAMP_W;
	localparam int unsigned DW = SW + QW;
	localparam int unsigned RK = QW + RW + 7;
	localparam int unsigned MW = QW + RW + 1;
	localparam logic [MW-1:0] RECIP = MW'(((64'd1 << RK) + 64'(tlss_pkg::RAMP_TOP) - 64'd1)
		/ 64'(tlss_pkg::RAMP_TOP));
	localparam logic signed [QW:0] FS_S = (QW+1)'(FORCE_FULL_SCALE);
	localparam logic signed [QW+1:0] SAT_HI = (QW+2)'(tlss_pkg::FORCE_MAX);
	localparam logic signed [QW+1:0] SAT_LO = (QW+2)'(tlss_pkg::FORCE_MIN);

	logic signed [31:0] center_q;
	logic [SW-1:0]      span_q;
	logic [30:0]        last_half_q;
	logic [RW-1:0]      ramp_q;
	logic [31:0]        next_tick_q;

	logic [30:0]                         half_q;
	logic signed [31:0]                  pos_q;
	logic                                dis_q;
	logic signed [tlss_pkg::FORCE_W-1:0] force_q;
	logic signed [32:0]                  rel_q;
	logic [SW-1:0]                       pen_q;
	logic                                dir_up_q;
	logic                                dir_dn_q;
	logic [QW-1:0]                       diff_mag_q;
	logic                                diff_neg_q;
	logic [QW+RW-1:0]                    ramp_prod_q;
	logic [QW-1:0]                       scaled_q;
	logic signed [tlss_pkg::FORCE_W-1:0] force_out_q;
	logic                                damper_q;

	logic [31:0]   half_lim;
	logic          shrink;
	logic [RW-1:0] ramp_base;
	logic          ramp_step;

	logic signed [33:0] over;
	logic signed [33:0] sum_rh;
	logic signed [33:0] under;
	logic               over_pos;
	logic               under_pos;
	logic [32:0]        pen_raw;
	logic [SW-1:0]      pen_cap;

	logic signed [QW:0] target;
	logic signed [QW:0] diff;

	logic [DW-1:0]       prod1;
	logic [QW+RW+MW-1:0] prod2;
	logic                div_done;
	logic [QW-1:0]       quot;

	logic signed [QW+1:0] corr;
	logic signed [QW+1:0] sum_f;
	logic signed [tlss_pkg::FORCE_W-1:0] result;

	assign half_lim = {1'b0, travel_half} + 32'(tlss_pkg::SHRINK_LIMIT);
	assign shrink = {1'b0, last_half_q} > half_lim;
	assign ramp_base = shrink ? '0 : ramp_q;
	assign ramp_step = (ramp_base < RW'(tlss_pkg::RAMP_TOP)) && (next_tick_q < tick_now);

	assign over = {rel_q[32], rel_q} - $signed({3'b000, half_q});
	assign sum_rh = {rel_q[32], rel_q} + $signed({3'b000, half_q});
	assign under = -sum_rh;
	assign over_pos = !over[33] && (over != '0);
	assign under_pos = !under[33] && (under != '0);

	always_comb begin
		pen_raw = '0;
		if (over_pos) begin
			pen_raw = over[32:0];
		end else if (under_pos) begin
			pen_raw = under[32:0];
		end
		pen_cap = (pen_raw > {17'b0, span_q}) ? span_q : pen_raw[SW-1:0];
	end

	always_comb begin
		target = '0;
		if (dir_up_q) begin
			target = FS_S;
		end else if (dir_dn_q) begin
			target = -FS_S;
		end
		diff = target - (QW+1)'(force_q);
	end

	assign prod1 = diff_mag_q * pen_q;
	assign prod2 = ramp_prod_q * RECIP;

	tlss_div #(
		.QW(QW),
		.VW(SW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.dividend(prod1),
		.divisor(span_q),
		.done(div_done),
		.quotient(quot)
	);

	assign stat.skip = dis_q || (pen_q == '0);
	assign stat.div_done = div_done;

	always_comb begin
		corr = diff_neg_q ? -$signed({2'b00, scaled_q}) : $signed({2'b00, scaled_q});
		sum_f = (QW+2)'(force_q) + corr;
		if (sum_f > SAT_HI) begin
			result = tlss_pkg::FORCE_W'(SAT_HI);
		end else if (sum_f < SAT_LO) begin
			result = tlss_pkg::FORCE_W'(SAT_LO);
		end else begin
			result = sum_f[tlss_pkg::FORCE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '0;
			span_q <= SW'(1);
			last_half_q <= '0;
			ramp_q <= '0;
			next_tick_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					tlss_pkg::CFG_ENCODER_CENTER: begin
						center_q <= cfg_data;
					end
					tlss_pkg::CFG_TRANSITION_SPAN: begin
						span_q <= cfg_data[SW-1:0];
					end
					default: begin
					end
				endcase
			end
			if (cmd.load) begin
				last_half_q <= travel_half;
				ramp_q <= ramp_step ? ramp_base + RW'(1) : ramp_base;
				if (ramp_step) begin
					next_tick_q <= tick_now + 32'(tlss_pkg::RAMP_STEP_TICKS);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			half_q <= travel_half;
			pos_q <= encoder_position;
			dis_q <= effects_disabled;
			force_q <= force_in;
		end
		if (cmd.rel) begin
			rel_q <= {pos_q[31], pos_q} - {center_q[31], center_q};
		end
		if (cmd.pen) begin
			pen_q <= pen_cap;
			dir_up_q <= under_pos;
			dir_dn_q <= over_pos;
		end
		if (cmd.diff) begin
			diff_neg_q <= diff[QW];
			diff_mag_q <= diff[QW] ? QW'(-diff) : diff[QW-1:0];
		end
		if (cmd.ramp_mul) begin
			ramp_prod_q <= quot * ramp_q;
		end
		if (cmd.ramp_div) begin
			scaled_q <= prod2[RK +: QW];
		end
		if (cmd.fin) begin
			force_out_q <= stat.skip ? force_q : result;
			damper_q <= !stat.skip;
		end
	end

	assign force_out = force_out_q;
	assign damper_active = damper_q;

endmodule

// ----- hw/rtl/tlss_ctrl.sv -----
module tlss_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  tlss_pkg::tlss_stat_t stat,
	output tlss_pkg::tlss_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REL,
		ST_PEN,
		ST_DIFF,
		ST_DIVS,
		ST_DIV,
		ST_RMUL,
		ST_RDIV,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_REL:  cmd.rel = 1'b1;
			ST_PEN:  cmd.pen = 1'b1;
			ST_DIFF: cmd.diff = 1'b1;
			ST_DIVS: cmd.div_start = 1'b1;
			ST_RMUL: cmd.ramp_mul = 1'b1;
			ST_RDIV: cmd.ramp_div = 1'b1;
			ST_FIN:  cmd.fin = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_REL;
					end
				end
				ST_REL: begin
					state_q <= ST_PEN;
				end
				ST_PEN: begin
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					state_q <= stat.skip ? ST_FIN : ST_DIVS;
				end
				ST_DIVS: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (stat.div_done) begin
						state_q <= ST_RMUL;
					end
				end
				ST_RMUL: begin
					state_q <= ST_RDIV;
				end
				ST_RDIV: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/travel_limit_soft_stop.sv -----
// Soft travel-limit stop for a force-feedback motor, one beat per service tick.
// Input channel (in_valid / in_stall) carries tick time, half range, encoder
// position, disable flag and force command; output channel (out_valid /
// out_stall) returns the blended force and the damper flag, one beat per input.
// The user writes registers via cfg_wr_en/cfg_index/cfg_data only while idle;
// not enforced by the block. Index 0: encoder center, 1: transition span.
// An item that is disabled or within the limits goes through the relative,
// penetration and difference steps straight to the final step; any other item
// also runs the divider start, the divide, the ramp multiply and the ramp
// divide. Items are taken one at a time; a new beat is taken in the cycle
// after the previous result is registered. The divide is a restoring divider,
// one quotient bit per cycle, that divides by the transition span; the scale
// by 100 is a reciprocal multiply in the ramp-divide step.
// A finished result waits in the output register while the next beat is
// accepted; the block holds its final state only while the output is stalled
// and a second result is ready.
// Reset clears the ramp, the tick schedule and the last half range, sets the
// center to 0 and the span to 1, and drops out_valid.
module travel_limit_soft_stop #(
	parameter int unsigned FORCE_FULL_SCALE = 65535
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [tlss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [31:0]                         cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [31:0]                         tick_now,
	input  logic [30:0]                         travel_half,
	input  logic signed [31:0]                  encoder_position,
	input  logic                                effects_disabled,
	input  logic signed [tlss_pkg::FORCE_W-1:0] force_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [tlss_pkg::FORCE_W-1:0] force_out,
	output logic                                damper_active
);

	tlss_pkg::tlss_cmd_t  cmd;
	tlss_pkg::tlss_stat_t stat;

	tlss_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat(stat),
		.cmd(cmd)
	);

	tlss_dp #(
		.FORCE_FULL_SCALE(FORCE_FULL_SCALE)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.tick_now(tick_now),
		.travel_half(travel_half),
		.encoder_position(encoder_position),
		.effects_disabled(effects_disabled),
		.force_in(force_in),
		.force_out(force_out),
		.damper_active(damper_active)
	);

endmodule
